[src/dcq_pkg.sv]
// Shared types and codes for the deduplicating call queue.
`default_nettype none
package dcq_pkg;

    typedef enum logic [2:0] {
        OUT_ADDED  = 3'd0,
        OUT_DUP    = 3'd1,
        OUT_FULL   = 3'd2,
        OUT_ZERO   = 3'd3,
        OUT_SERVED = 3'd4,
        OUT_EMPTY  = 3'd5
    } t_outcome;

    typedef enum logic {
        FUNC_CALL  = 1'b0,
        FUNC_SERVE = 1'b1
    } t_func;

    // per-cycle command broadcast to every queue cell
    typedef struct packed {
        logic clr;    // clear match flags
        logic scan;   // advance the match wave one cell
        logic shift;  // move every code one place toward the head
        logic load;   // write the call code into the selected cell
    } t_cell_ctrl;

    localparam int EXT_BITS      = 16;

endpackage
`default_nettype wire

[src/dcq_cell.sv]
// One queue slot: holds a code, passes codes toward the head, ripples the match flag.
`default_nettype none
module dcq_cell #(
    parameter int W = 8
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  dcq_pkg::t_cell_ctrl i_ctrl,
    input  wire                 i_sel,
    input  wire  [W-1:0]        i_code,
    input  wire  [W-1:0]        i_next_slot,
    input  wire                 i_hit,
    output logic [W-1:0]        o_slot,
    output logic                o_hit
);
    import dcq_pkg::*;

    logic [W-1:0] r_slot;
    logic         r_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
            r_hit  <= 1'b0;
        end else begin
            if (i_ctrl.clr) begin
                r_hit <= 1'b0;
            end else if (i_ctrl.scan) begin
                r_hit <= i_hit | (r_slot == i_code);
            end
            if (i_ctrl.shift) begin
                r_slot <= i_next_slot;
            end else if (i_ctrl.load && i_sel) begin
                r_slot <= i_code;
            end
        end
    end

    assign o_slot = r_slot;
    assign o_hit  = r_hit;

endmodule
`default_nettype wire

[src/dedup_call_queue_unit.sv]
// Top level of the deduplicating call queue: request sequencer, cell row and result register.
// Each request gives one result. A call with a nonzero code passes through S_SCAN, S_EXEC
// and S_POST, the match flag rippling one cell per cycle down the row of DEPTH cells in
// S_SCAN; a serve or a zero-code call goes straight to S_EXEC. One request is in work at a
// time; a new request is accepted while the previous result waits in the output register.
// Codes are queued in arrival order, code 0 is never stored, a new code for a full queue
// is dropped and a serve on an empty queue changes nothing. Reset clears the whole queue.
`default_nettype none
module dedup_call_queue_unit #(
    parameter int DEPTH     = 12,
    parameter int CODE_BITS = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [7:0]  i_s_tdata,   // code[7:0]
    input  wire         i_s_tuser,   // func
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [15:0] o_m_tdata    // head_code[7:0], entry_count[11:8], outcome[14:12], 0
);
    import dcq_pkg::*;

    localparam int FW = $clog2(DEPTH + 1);
    localparam int CW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC,
        S_POST
    } t_state;

    t_state             r_state;
    logic               r_func;
    logic [CODE_BITS-1:0] r_code;
    logic [FW-1:0]      r_fill;
    logic [CW-1:0]      r_cnt;
    t_outcome           r_outcome;
    logic               r_m_valid;
    logic [15:0]        r_m_data;

    t_cell_ctrl         w_ctrl;
    t_outcome           w_outcome;
    logic [CODE_BITS-1:0] w_slot [DEPTH];
    logic [DEPTH-1:0]   w_hit;
    logic [EXT_BITS-1:0] w_code_ext;
    logic [EXT_BITS-1:0] w_head_ext;
    logic [7:0]         w_fill_ext;
    logic               w_accept;
    logic               w_out_free;

    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_m_valid || i_m_tready;
    assign w_code_ext = EXT_BITS'(i_s_tdata);
    assign w_head_ext = EXT_BITS'(w_slot[0]);
    assign w_fill_ext = 8'(r_fill);

    always_comb begin
        w_outcome = OUT_ZERO;
        if (r_func == FUNC_SERVE) begin
            w_outcome = (r_fill == '0) ? OUT_EMPTY : OUT_SERVED;
        end else if (r_code == '0) begin
            w_outcome = OUT_ZERO;
        end else if (w_hit[DEPTH-1]) begin
            w_outcome = OUT_DUP;
        end else if (r_fill == FW'(DEPTH)) begin
            w_outcome = OUT_FULL;
        end else begin
            w_outcome = OUT_ADDED;
        end
    end

    always_comb begin
        w_ctrl.clr   = w_accept;
        w_ctrl.scan  = (r_state == S_SCAN);
        w_ctrl.shift = (r_state == S_EXEC) && (w_outcome == OUT_SERVED);
        w_ctrl.load  = (r_state == S_EXEC) && (w_outcome == OUT_ADDED);
    end

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [CODE_BITS-1:0] w_next;
        logic                 w_hit_in;
        if (k == DEPTH - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_slot[k+1];
        end
        if (k == 0) begin : g_first
            assign w_hit_in = 1'b0;
        end else begin : g_rest
            assign w_hit_in = w_hit[k-1];
        end
        dcq_cell #(
            .W (CODE_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (w_ctrl),
            .i_sel       (r_fill == FW'(k)),
            .i_code      (r_code),
            .i_next_slot (w_next),
            .i_hit       (w_hit_in),
            .o_slot      (w_slot[k]),
            .o_hit       (w_hit[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_cnt     <= '0;
            r_m_valid <= 1'b0;
            r_func    <= FUNC_CALL;
            r_code    <= '0;
            r_outcome <= OUT_ZERO;
        end else begin
            if (r_state == S_POST && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (r_m_valid && i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_func <= i_s_tuser;
                        r_code <= w_code_ext[CODE_BITS-1:0];
                        r_cnt  <= '0;
                        if (i_s_tuser == FUNC_CALL && w_code_ext[CODE_BITS-1:0] != '0) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_EXEC;
                        end
                    end
                end
                S_SCAN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(DEPTH - 1)) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_outcome <= w_outcome;
                    if (w_outcome == OUT_SERVED) begin
                        r_fill <= r_fill - 1'b1;
                    end else if (w_outcome == OUT_ADDED) begin
                        r_fill <= r_fill + 1'b1;
                    end
                    r_state <= S_POST;
                end
                S_POST: begin
                    if (w_out_free) begin
                        r_m_data  <= {1'b0, r_outcome, w_fill_ext[3:0], w_head_ext[7:0]};
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(DEPTH))
        else $error("queue fill beyond depth");

    a_head_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == '0) == (w_slot[0] == '0))
        else $error("head code disagrees with fill");

    a_serve_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && w_outcome == OUT_SERVED) |=> (r_fill == $past(r_fill) - 1'b1))
        else $error("serve did not drop fill");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && w_outcome == OUT_FULL) |=> $stable(r_fill))
        else $error("dropped call changed fill");

endmodule
`default_nettype wire

[verif/dedup_call_queue_unit_tb.sv]
// Testbench for dedup_call_queue_unit: directed and random call/serve items checked against a queue model.
`timescale 1ns / 100ps
module dedup_call_queue_unit_tb;
    import dcq_pkg::*;

    localparam int DEPTH        = 12;
    localparam int RANDOM_ITEMS = 1080;
    localparam int HOLD_AT      = 600;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic [7:0] head;
        logic [3:0] count;
        t_outcome   outcome;
    } t_queue_view;

    class call_queue_scoreboard;
        logic [7:0]  slot [DEPTH];
        int          fill;
        t_queue_view pending_views [$];
        int          errors;

        function new();
            foreach (slot[k]) slot[k] = '0;
            fill   = 0;
            errors = 0;
        endfunction

        function void note_request(t_func f, logic [7:0] c);
            t_outcome    oc;
            bit          hit;
            t_queue_view v;
            if (f == FUNC_CALL) begin
                hit = 0;
                for (int k = 0; k < fill; k++)
                    if (slot[k] == c) hit = 1;
                if (c == 0) oc = OUT_ZERO;
                else if (hit) oc = OUT_DUP;
                else if (fill == DEPTH) oc = OUT_FULL;
                else begin
                    slot[fill] = c;
                    fill++;
                    oc = OUT_ADDED;
                end
            end else if (fill == 0) begin
                oc = OUT_EMPTY;
            end else begin
                for (int k = 0; k < DEPTH - 1; k++) slot[k] = slot[k + 1];
                slot[DEPTH - 1] = '0;
                fill--;
                oc = OUT_SERVED;
            end
            v.head    = (fill > 0) ? slot[0] : 8'd0;
            v.count   = fill[3:0];
            v.outcome = oc;
            pending_views.push_back(v);
        endfunction

        function void check_result(logic [15:0] d);
            t_queue_view want;
            if (pending_views.size() == 0) begin
                $display("%0t: unexpected result, actual %h", $time, d);
                errors++;
                return;
            end
            want = pending_views.pop_front();
            if (d[7:0] !== want.head) begin
                $display("%0t: head_code expected %0d actual %0d", $time, want.head, d[7:0]);
                errors++;
            end
            if (d[11:8] !== want.count) begin
                $display("%0t: entry_count expected %0d actual %0d", $time, want.count, d[11:8]);
                errors++;
            end
            if (d[14:12] !== want.outcome) begin
                $display("%0t: outcome expected %0d actual %0d", $time, want.outcome, d[14:12]);
                errors++;
            end
        endfunction
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tready = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [15:0] m_tdata;

    call_queue_scoreboard sb = new();
    int items_sent = 0;
    bit quiet      = 1'b0;
    int hold_left  = 0;
    bit hold_done  = 1'b0;

    dedup_call_queue_unit i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    task send_item(t_func f, logic [7:0] c);
        while (!quiet && $urandom_range(99) < 36) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= f;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_request(f, c);
        items_sent <= items_sent + 1;
        quiet      <= (items_sent >= 200 && items_sent < 450);
    endtask

    task send_call(logic [7:0] c);
        send_item(FUNC_CALL, c);
    endtask

    task send_serve(logic [7:0] c);
        send_item(FUNC_SERVE, c);
    endtask

    function logic [7:0] pick_code();
        int r;
        r = $urandom_range(99);
        if (r < 8) return 8'd0;
        if (r < 55) return 8'($urandom_range(1, 20));
        if (r < 65) return 8'($urandom_range(240, 255));
        return 8'($urandom_range(0, 255));
    endfunction

    // result side: random stalls, one long hold-off so the block backs up
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else if (!hold_done && items_sent >= HOLD_AT) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                m_tready  <= 1'b0;
            end else begin
                m_tready <= quiet || ($urandom_range(99) >= 36);
            end
        end
    end

    initial begin
        int call_pct;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty serve, zero code, code extremes, duplicate
        send_serve(8'hFF);
        send_call(8'h00);
        send_call(8'hFF);
        send_call(8'h01);
        send_call(8'hFF);
        send_call(8'h80);
        send_call(8'h7F);
        send_call(8'h55);
        send_call(8'hAA);
        for (int k = 2; k <= 7; k++) send_call(8'(k));
        // queue full: new code dropped, duplicate and zero still flagged
        send_call(8'h09);
        send_call(8'h01);
        send_call(8'h00);
        send_serve(8'h00);
        send_call(8'h09);
        send_call(8'h0A);
        send_serve(8'hFF);

        call_pct = 80;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) call_pct = (call_pct == 80) ? 25 : 80;
            if ($urandom_range(99) < call_pct) send_call(pick_code());
            else send_serve(8'($urandom_range(0, 255)));
        end
        s_tvalid <= 1'b0;

        while (sb.pending_views.size() != 0) @(posedge clk);
        repeat (DEPTH + 10) @(posedge clk);

        if (sb.errors == 0 && sb.pending_views.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
